[src/crs_pkg.sv]
// shared types and constants for the circle row order search
package crs_pkg;

  localparam int MAX_CIRCLES_DEF = 8;
  localparam int RADIUS_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int OUT_LEN_W = 22;
  localparam int POS_W     = 3;
  localparam int NUM_W     = 4;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PRE_MUL,
    S_PRE_SQRT,
    S_PRE_WR,
    S_INIT,
    S_SWAP,
    S_PC_RD,
    S_PC_ACC,
    S_CHECK,
    S_MEAS,
    S_MEAS_CMP,
    S_NEXT,
    S_EMIT,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic ld;
    logic sq_start;
    logic pre_wr;
    logic init;
    logic swap;
    logic pc_rd;
    logic pc_acc;
    logic check;
    logic meas;
    logic meas_cmp;
    logic nxt;
    logic emit;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic sq_done;
    logic pre_last;
    logic pc_none;
    logic pc_last;
    logic fits;
    logic deep_full;
    logic meas_last;
    logic has_next;
    logic at_top;
    logic out_last;
  } sts_t;

endpackage

[src/crs_sqrt.sv]
// restoring integer square root, one result bit per cycle, rounds down
module crs_sqrt import crs_pkg::*; #(
  parameter int SW = 19
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*SW-1:0] op_i,
  output logic            done_o,
  output logic [SW-1:0]   root_o
);

  localparam int CNT_W = $clog2(SW + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [2*SW-1:0]   op_q;
  logic [SW:0]       rem_q;
  logic [SW-1:0]     root_q;
  logic [SW+2:0]     rem_sh;
  logic [SW+2:0]     test;
  logic              take;

  assign rem_sh = {rem_q, op_q[2*SW-1 -: 2]};
  assign test   = (SW + 3)'({root_q, 2'b01});
  assign take   = rem_sh >= test;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q <= op_q << 2;
      if (take) begin
        rem_q  <= rem_sh[SW:0] - test[SW:0];
        root_q <= {root_q[SW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[SW:0];
        root_q <= {root_q[SW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[src/crs_ctrl.sv]
// search controller: load, offset table fill, backtracking walk, result emission
module crs_ctrl import crs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        s_ready_o = 1'b1;
        cmd_o.ld  = s_valid_i;
        if (s_valid_i && sts_i.go) state_d = S_PRE_MUL;
      end
      S_PRE_MUL: begin
        cmd_o.sq_start = 1'b1;
        state_d = S_PRE_SQRT;
      end
      S_PRE_SQRT: begin
        if (sts_i.sq_done) state_d = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd_o.pre_wr = 1'b1;
        state_d = sts_i.pre_last ? S_INIT : S_PRE_MUL;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d = sts_i.pc_none ? S_CHECK : S_PC_RD;
      end
      S_PC_RD: begin
        cmd_o.pc_rd = 1'b1;
        state_d = S_PC_ACC;
      end
      S_PC_ACC: begin
        cmd_o.pc_acc = 1'b1;
        state_d = sts_i.pc_last ? S_CHECK : S_PC_RD;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (!sts_i.fits) state_d = S_NEXT;
        else if (sts_i.deep_full) state_d = S_MEAS;
        else state_d = S_SWAP;
      end
      S_MEAS: begin
        cmd_o.meas = 1'b1;
        if (sts_i.meas_last) state_d = S_MEAS_CMP;
      end
      S_MEAS_CMP: begin
        cmd_o.meas_cmp = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.nxt = 1'b1;
        if (sts_i.has_next) state_d = S_SWAP;
        else if (sts_i.at_top) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = S_HOLD;
      end
      S_HOLD: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (sts_i.out_last) begin
            cmd_o.done = 1'b1;
            state_d = S_LOAD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

[src/crs_dp.sv]
// search datapath: radii, offset table, permutation stack, centers, best ordering
module crs_dp import crs_pkg::*; #(
  parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  logic                   is_last_i,
  output logic [OUT_LEN_W-1:0]   best_length_o,
  output logic [POS_W-1:0]       position_o,
  output logic [NUM_W-1:0]       circle_number_o,
  output logic                   last_o
);

  localparam int R     = RADIUS_BITS;
  localparam int F     = FRAC_BITS;
  localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
  localparam int SW    = R + F + 1;
  localparam int VW    = 2 * SW;
  localparam int CW    = SW + IDX_W;
  localparam int LW    = CW + 1;
  localparam int RF_W  = R + F;
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;
  localparam logic [63:0] LEN_MAX = (64'd1 << OUT_LEN_W) - 64'd1;

  logic [R-1:0]     in_r_q   [MAX_CIRCLES];
  logic [CNT_W-1:0] cnt_q, n_q, k_q, j_q;
  logic [IDX_W-1:0] pa_q, pb_q, p_q;
  logic [SW-1:0]    mem      [DEPTH];
  logic [SW-1:0]    rd_q;
  logic [IDX_W-1:0] perm_q   [MAX_CIRCLES];
  logic [IDX_W-1:0] choice_q [MAX_CIRCLES];
  logic [IDX_W-1:0] bidx_q   [MAX_CIRCLES];
  logic [CW-1:0]    cen_q    [MAX_CIRCLES];
  logic [CW-1:0]    x_q;
  logic             found_q;
  logic [LW-1:0]    best_q;
  logic signed [CW+1:0] lo_q, hi_q;
  logic [MAX_CIRCLES-1:0] matched_q;
  logic [OUT_LEN_W-1:0] len_q;
  logic [POS_W-1:0] pos_q;
  logic [NUM_W-1:0] num_q;
  logic             olast_q;

  logic [IDX_W-1:0] ki, ji, pk, ck;
  logic [CNT_W-1:0] kn;
  logic [RF_W-1:0]  rk_fx, r0_fx, rj_fx;
  logic [LW-1:0]    lhs, span;
  logic [CW-1:0]    cand;
  logic signed [CW+1:0] cs, rs, lv, hv;
  logic [2*R-1:0]   prod;
  logic [VW-1:0]    sq_op;
  logic             sq_done;
  logic [SW-1:0]    root;
  logic [R-1:0]     rb_p;
  logic [IDX_W-1:0] mj;
  logic             mfound;
  logic [63:0]      best64;
  logic             better;

  assign ki    = k_q[IDX_W-1:0];
  assign ji    = j_q[IDX_W-1:0];
  assign kn    = k_q + CNT_W'(1);
  assign pk    = perm_q[ki];
  assign ck    = choice_q[ki];
  assign rk_fx = RF_W'(in_r_q[pk]) << F;
  assign r0_fx = RF_W'(in_r_q[perm_q[0]]) << F;
  assign rj_fx = RF_W'(in_r_q[perm_q[ji]]) << F;
  assign lhs   = LW'(x_q) + LW'(rk_fx) + LW'(r0_fx);
  assign cand  = cen_q[ji] + CW'(rd_q);
  assign cs    = $signed({2'b00, cen_q[ji]});
  assign rs    = $signed((CW + 2)'(rj_fx));
  assign lv    = cs - rs;
  assign hv    = cs + rs;
  assign span  = LW'(hi_q - lo_q);
  assign better = !found_q || (span < best_q);

  // tangent offset operand: 4*ra*rb scaled by two fraction shifts
  assign prod  = (2 * R)'(in_r_q[pa_q]) * (2 * R)'(in_r_q[pb_q]);
  assign sq_op = VW'(prod) << (2 + 2 * F);

  crs_sqrt #(.SW(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .op_i    (sq_op),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // first unused input whose radius equals the best ordering's radius here
  always_comb begin
    rb_p   = in_r_q[bidx_q[p_q]];
    mj     = '0;
    mfound = 1'b0;
    for (int i = 0; i < MAX_CIRCLES; i++) begin
      if (!mfound && (CNT_W'(i) < n_q) && !matched_q[i] && (in_r_q[i] == rb_p)) begin
        mfound = 1'b1;
        mj     = IDX_W'(i);
      end
    end
  end

  assign best64 = 64'(best_q);

  always_comb begin
    sts_o           = '0;
    sts_o.go        = is_last_i || (cnt_q + CNT_W'(1) == CNT_W'(MAX_CIRCLES));
    sts_o.sq_done   = sq_done;
    sts_o.pre_last  = (CNT_W'(pa_q) + CNT_W'(1) == n_q) && (CNT_W'(pb_q) + CNT_W'(1) == n_q);
    sts_o.pc_none   = (k_q == '0);
    sts_o.pc_last   = (j_q + CNT_W'(1) == k_q);
    sts_o.fits      = !found_q || (lhs < best_q);
    sts_o.deep_full = (kn == n_q);
    sts_o.meas_last = (j_q + CNT_W'(1) == n_q);
    sts_o.has_next  = (CNT_W'(ck) + CNT_W'(1) < n_q);
    sts_o.at_top    = (k_q == '0);
    sts_o.out_last  = olast_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
      j_q       <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      p_q       <= '0;
      found_q   <= 1'b0;
      matched_q <= '0;
      for (int i = 0; i < MAX_CIRCLES; i++) begin
        perm_q[i]   <= '0;
        choice_q[i] <= '0;
      end
    end else begin
      if (cmd_i.ld) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (sts_o.go) begin
          n_q  <= cnt_q + CNT_W'(1);
          pa_q <= '0;
          pb_q <= '0;
        end
      end
      if (cmd_i.pre_wr) begin
        if (CNT_W'(pb_q) + CNT_W'(1) == n_q) begin
          pb_q <= '0;
          pa_q <= pa_q + IDX_W'(1);
        end else begin
          pb_q <= pb_q + IDX_W'(1);
        end
      end
      if (cmd_i.init) begin
        for (int i = 0; i < MAX_CIRCLES; i++) perm_q[i] <= IDX_W'(i);
        choice_q[0] <= '0;
        found_q     <= 1'b0;
        k_q         <= '0;
        p_q         <= '0;
        matched_q   <= '0;
      end
      if (cmd_i.swap) begin
        perm_q[ki] <= perm_q[ck];
        perm_q[ck] <= perm_q[ki];
        j_q        <= '0;
      end
      if (cmd_i.pc_acc || cmd_i.meas) j_q <= j_q + CNT_W'(1);
      if (cmd_i.check && sts_o.fits) begin
        j_q <= '0;
        if (!sts_o.deep_full) begin
          k_q <= kn;
          choice_q[kn[IDX_W-1:0]] <= kn[IDX_W-1:0];
        end
      end
      if (cmd_i.meas_cmp && better) found_q <= 1'b1;
      if (cmd_i.nxt) begin
        perm_q[ki] <= perm_q[ck];
        perm_q[ck] <= perm_q[ki];
        if (sts_o.has_next) begin
          choice_q[ki] <= ck + IDX_W'(1);
        end else begin
          choice_q[ki] <= '0;
          if (k_q != '0) k_q <= k_q - CNT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        matched_q[mj] <= 1'b1;
        p_q           <= p_q + IDX_W'(1);
      end
      if (cmd_i.done) begin
        cnt_q     <= '0;
        matched_q <= '0;
      end
    end
  end

  // offset table
  always_ff @(posedge clk_i) begin
    if (cmd_i.pre_wr) mem[{pa_q, pb_q}] <= root;
    if (cmd_i.pc_rd) rd_q <= mem[{pk, perm_q[ji]}];
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) in_r_q[cnt_q[IDX_W-1:0]] <= radius_i;
    if (cmd_i.swap) x_q <= '0;
    if (cmd_i.pc_acc && (cand > x_q)) x_q <= cand;
    if (cmd_i.check && sts_o.fits) cen_q[ki] <= x_q;
    if (cmd_i.meas) begin
      if (j_q == '0 || lv < lo_q) lo_q <= lv;
      if (j_q == '0 || hv > hi_q) hi_q <= hv;
    end
    if (cmd_i.meas_cmp && better) begin
      best_q <= span;
      for (int i = 0; i < MAX_CIRCLES; i++) bidx_q[i] <= perm_q[i];
    end
    if (cmd_i.emit) begin
      len_q   <= (best64 > LEN_MAX) ? '1 : best64[OUT_LEN_W-1:0];
      pos_q   <= POS_W'(p_q);
      num_q   <= NUM_W'(mj) + NUM_W'(1);
      olast_q <= (CNT_W'(p_q) + CNT_W'(1) == n_q);
    end
  end

  assign best_length_o   = len_q;
  assign position_o      = pos_q;
  assign circle_number_o = num_q;
  assign last_o          = olast_q;

endmodule

[src/circle_row_order_search.sv]
// top level of the circle row order search
// flow: radii load one item per cycle while in the load state; after the closing item
// the offset table gets one root per radius pair (square root one bit a cycle, SW =
// RADIUS_BITS+FRAC_BITS+1); the walk swaps, adds an offset per earlier circle placed and
// checks the fit at each node; results leave one at a time, each held until taken
// reset: asynchronous active low, clears the count, flags, stack and controller state
module circle_row_order_search import crs_pkg::*; #(
  parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input items: one circle radius each
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((RADIUS_BITS+7)/8)*8-1:0]     s_axis_tdata,  // radius
  input  logic                                 s_axis_tlast,  // is_last
  // result items: one per position of the best ordering
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0] m_axis_tdata,  // best_length[21:0], position[24:22], circle_number[28:25]
  output logic                                 m_axis_tlast   // last
);

  cmd_t cmd;
  sts_t sts;
  logic [OUT_LEN_W-1:0] best_length;
  logic [POS_W-1:0]     position;
  logic [NUM_W-1:0]     circle_number;

  // controller owns the handshakes, datapath holds all arithmetic
  crs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  crs_dp #(
    .MAX_CIRCLES (MAX_CIRCLES),
    .RADIUS_BITS (RADIUS_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .radius_i        (s_axis_tdata[RADIUS_BITS-1:0]),
    .is_last_i       (s_axis_tlast),
    .best_length_o   (best_length),
    .position_o      (position),
    .circle_number_o (circle_number),
    .last_o          (m_axis_tlast)
  );

  // pack result fields lowest first, pad to whole bytes
  assign m_axis_tdata = {3'b000, circle_number, position, best_length};

endmodule

[tb/testbench.sv]
// self-checking testbench for the circle row order search
`timescale 1ns / 1ps

module testbench;
  import crs_pkg::*;

  localparam int NC = MAX_CIRCLES_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000000;

  typedef struct {
    logic [OUT_LEN_W-1:0] len;
    logic [POS_W-1:0]     pos;
    logic [NUM_W-1:0]     num;
    logic                 last;
  } placement_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // radius
  logic        s_axis_tlast = 1'b0;  // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // best_length, position, circle_number
  logic        m_axis_tlast;  // last

  circle_row_order_search dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencing knobs, set by the tests
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  // counters
  int errors = 0;
  int sets_searched = 0;
  int placements_checked = 0;
  int radii_sent = 0;

  // predictor copy of the block state
  logic [9:0]  loaded_radii[NC];
  int          loaded_count = 0;
  longint      trial_radii[NC];
  longint      trial_centers[NC];
  longint      shortest_radii[NC];
  longint      shortest_len;
  bit          shortest_found;
  placement_t  expected_placements[$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // center of circle k: the largest tangent position over every earlier circle
  function automatic longint tangent_center(int k);
    longint c = 0;
    longint x;
    longint unsigned prod;
    for (int i = 0; i < k; i++) begin
      prod = (longint'(trial_radii[k]) * trial_radii[i]) << 2;
      x = trial_centers[i] + longint'(floor_sqrt(prod << (2 * FB)));
      if (x > c) c = x;
    end
    return c;
  endfunction

  function automatic void score_row(int n);
    longint lo = 0, hi = 0, l, h;
    for (int i = 0; i < n; i++) begin
      l = trial_centers[i] - (trial_radii[i] << FB);
      h = trial_centers[i] + (trial_radii[i] << FB);
      if (i == 0 || l < lo) lo = l;
      if (i == 0 || h > hi) hi = h;
    end
    if (!shortest_found || (hi - lo) < shortest_len) begin
      shortest_len = hi - lo;
      shortest_found = 1'b1;
      for (int i = 0; i < n; i++) shortest_radii[i] = trial_radii[i];
    end
  endfunction

  // backtracking over orderings, swap based, with the same pruning as the block
  function automatic void explore_orders(int k, int n);
    longint t, x;
    if (k >= n) begin
      score_row(n);
      return;
    end
    for (int i = k; i < n; i++) begin
      t = trial_radii[k]; trial_radii[k] = trial_radii[i]; trial_radii[i] = t;
      x = tangent_center(k);
      if (!shortest_found ||
          (x + (trial_radii[k] << FB) + (trial_radii[0] << FB)) < shortest_len) begin
        trial_centers[k] = x;
        explore_orders(k + 1, n);
      end
      t = trial_radii[k]; trial_radii[k] = trial_radii[i]; trial_radii[i] = t;
    end
  endfunction

  // accepted radius item: load it, and on the closing item predict the ordering
  function automatic void predict_row(logic [9:0] r, logic is_last);
    int n;
    bit used[NC];
    placement_t p;
    if (loaded_count >= NC) loaded_count = 0;
    loaded_radii[loaded_count] = r;
    loaded_count++;
    if (!is_last && loaded_count < NC) return;
    n = loaded_count;
    for (int i = 0; i < n; i++) trial_radii[i] = loaded_radii[i];
    shortest_found = 1'b0;
    shortest_len = 64'hFFFFFF;
    explore_orders(0, n);
    foreach (used[j]) used[j] = 1'b0;
    for (int i = 0; i < n; i++) begin
      p.num = '0;
      // first unused arrival with the same radius
      for (int j = 0; j < n; j++) begin
        if (!used[j] && loaded_radii[j] == shortest_radii[i]) begin
          used[j] = 1'b1;
          p.num = NUM_W'(j + 1);
          break;
        end
      end
      // saturate to the output width
      p.len = (shortest_len > 64'h3FFFFF) ? '1 : OUT_LEN_W'(shortest_len);
      p.pos = POS_W'(i);
      p.last = (i + 1 == n);
      expected_placements.push_back(p);
    end
    loaded_count = 0;
    sets_searched++;
  endfunction

  // sends one radius item, with a random idle gap ahead of it
  task automatic send_radius(logic [9:0] r, logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, r};
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_row(r, is_last);
    radii_sent++;
  endtask

  // a set of n random radii; the eighth may close the set without a last mark
  task automatic send_random_set(int n, int max_r);
    for (int i = 0; i < n; i++)
      send_radius(10'($urandom_range(max_r)),
                  (i == n - 1) && (n < NC || $urandom_range(1)));
  endtask

  // drop the input valid and wait until every expected result came out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker against the oldest expected placement
  always @(posedge clk_i) begin
    placement_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_placements.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_placements.pop_front();
        placements_checked++;
        if (m_axis_tdata[21:0] !== e.len) begin
          $error("best_length expected %0d actual %0d", e.len, m_axis_tdata[21:0]);
          errors++;
        end
        if (m_axis_tdata[24:22] !== e.pos) begin
          $error("position expected %0d actual %0d", e.pos, m_axis_tdata[24:22]);
          errors++;
        end
        if (m_axis_tdata[28:25] !== e.num) begin
          $error("circle_number expected %0d actual %0d", e.num, m_axis_tdata[28:25]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last expected %0d actual %0d", e.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("circle_row_order_search test failed");
      $finish;
    end
  end

  // extremes, radius zero, ties, a full set without a last mark
  task automatic test_directed();
    send_radius(10'd1, 1'b1);
    send_radius(10'd1023, 1'b1);
    send_radius(10'd0, 1'b0);
    send_radius(10'd0, 1'b1);
    send_radius(10'd5, 1'b0);
    send_radius(10'd5, 1'b0);
    send_radius(10'd5, 1'b1);
    send_radius(10'd1023, 1'b0);
    send_radius(10'd1, 1'b0);
    send_radius(10'd512, 1'b0);
    send_radius(10'd0, 1'b1);
    // full set closes on its own
    send_radius(10'd1023, 1'b0);
    send_radius(10'd341, 1'b0);
    send_radius(10'd682, 1'b0);
    send_radius(10'd1, 1'b0);
    send_radius(10'd1023, 1'b0);
    send_radius(10'd100, 1'b0);
    send_radius(10'd0, 1'b0);
    send_radius(10'd7, 1'b0);
    wait_drained();
  endtask

  // random sets, mostly small so the exhaustive search stays short
  task automatic test_random_sets(int idle, int stall, int items);
    int sent = 0;
    int n;
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    while (sent < items) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
      send_random_set(n, ($urandom_range(3) == 0) ? 15 : 1023);
      sent += n;
    end
    wait_drained();
  endtask

  // long receiver hold-off while radii keep coming, so the input stalls
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 3000;
    for (int s = 0; s < 6; s++) send_random_set($urandom_range(2, 4), 1023);
    wait_drained();
  endtask

  task automatic test_full_sets();
    sender_idle_pct = 10;
    recv_stall_pct = 10;
    send_random_set(NC, 1023);
    send_random_set(NC, 3);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sets(0, 0, 60);
    test_random_sets(76, 0, 55);
    test_random_sets(0, 76, 55);
    test_random_sets(31, 31, 55);
    test_output_backpressure();
    test_full_sets();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk_i);
    $display("covered %0d radii in %0d searched sets, %0d result items checked",
             radii_sent, sets_searched, placements_checked);
    $display("with idle and stall phases, a long output hold-off and full sets");
    if (errors == 0 && expected_placements.size() == 0) begin
      $display("circle_row_order_search test passed");
    end else begin
      $display("circle_row_order_search test failed");
    end
    $finish;
  end

endmodule
